[rtl/core/csb_pkg.sv]
// csb_pkg: shared types, register indexes and reset values for the clipped sprite blitter
// no dependencies; used by every module under rtl/core
package csb_pkg;

	localparam int COORD_BITS_DEF = 11;
	localparam int ADDR_BITS_DEF  = 19;

	localparam int IDX_BITS = 3;

	localparam logic [IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_SPRITE_X      = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_SPRITE_Y      = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_SPRITE_WIDTH  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_SPRITE_HEIGHT = 3'd5;

	localparam logic [9:0] SCREEN_WIDTH_RST  = 10'd320;
	localparam logic [8:0] SCREEN_HEIGHT_RST = 9'd200;
	localparam logic [9:0] SPRITE_WIDTH_RST  = 10'd8;
	localparam logic [9:0] SPRITE_HEIGHT_RST = 10'd8;

	typedef struct packed {
		logic [9:0] screen_width;
		logic [8:0] screen_height;
		logic [9:0] sprite_width;
		logic [9:0] sprite_height;
	} cfg_t;

	typedef struct packed {
		logic       visible;
		logic [9:0] x;
		logic [8:0] y;
		logic [7:0] color;
	} s1_t;

endpackage

[rtl/core/csb_cfg.sv]
// csb_cfg: configuration register file of the clipped sprite blitter
// depends on csb_pkg
module csb_cfg #(
	parameter int COORD_BITS = csb_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [csb_pkg::IDX_BITS-1:0]        cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	output csb_pkg::cfg_t                       cfg,
	output logic signed [COORD_BITS-1:0]        sprite_x,
	output logic signed [COORD_BITS-1:0]        sprite_y
);

	csb_pkg::cfg_t                cfg_q;
	logic signed [COORD_BITS-1:0] sprite_x_q;
	logic signed [COORD_BITS-1:0] sprite_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= csb_pkg::SCREEN_WIDTH_RST;
			cfg_q.screen_height <= csb_pkg::SCREEN_HEIGHT_RST;
			cfg_q.sprite_width  <= csb_pkg::SPRITE_WIDTH_RST;
			cfg_q.sprite_height <= csb_pkg::SPRITE_HEIGHT_RST;
			sprite_x_q          <= '0;
			sprite_y_q          <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				csb_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[9:0];
				csb_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[8:0];
				csb_pkg::REG_SPRITE_X:      sprite_x_q          <= $signed(cfg_data);
				csb_pkg::REG_SPRITE_Y:      sprite_y_q          <= $signed(cfg_data);
				csb_pkg::REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data[9:0];
				csb_pkg::REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg      = cfg_q;
	assign sprite_x = sprite_x_q;
	assign sprite_y = sprite_y_q;

endmodule

[rtl/core/csb_coord.sv]
// csb_coord: sprite column/row counters, screen coordinate and clip test, first pipeline stage
// depends on csb_pkg
module csb_coord #(
	parameter int COORD_BITS = csb_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_ready,
	input  logic [7:0]                   pixel_color,
	input  csb_pkg::cfg_t                cfg,
	input  logic signed [COORD_BITS-1:0] sprite_x,
	input  logic signed [COORD_BITS-1:0] sprite_y,
	output logic                         valid_s1,
	output csb_pkg::s1_t                 data_s1,
	input  logic                         s1_ready
);

	localparam int SXW = COORD_BITS + 2;

	logic [9:0]            col_q;
	logic [9:0]            row_q;
	logic                  accept;
	logic signed [SXW-1:0] sx;
	logic signed [SXW-1:0] sy;
	logic                  vis;
	logic                  col_end;
	logic                  row_end;

	assign pixel_ready = !valid_s1 || s1_ready;
	assign accept      = pixel_valid && pixel_ready;

	assign sx = SXW'(sprite_x) + $signed({{(SXW-10){1'b0}}, col_q});
	assign sy = SXW'(sprite_y) + $signed({{(SXW-10){1'b0}}, row_q});

	// on screen when both coordinates are non-negative and inside the mode size
	assign vis = !sx[SXW-1] && (sx < $signed({{(SXW-10){1'b0}}, cfg.screen_width}))
		&& !sy[SXW-1] && (sy < $signed({{(SXW-9){1'b0}}, cfg.screen_height}));

	assign col_end = ({1'b0, col_q} + 11'd1) >= {1'b0, cfg.sprite_width};
	assign row_end = ({1'b0, row_q} + 11'd1) >= {1'b0, cfg.sprite_height};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? 10'd0 : row_q + 10'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_ready) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.visible <= vis;
			data_s1.x       <= sx[9:0];
			data_s1.y       <= sy[8:0];
			data_s1.color   <= pixel_color;
		end
	end

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not reach stage one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_ready |=> valid_s1 && $stable(data_s1))
		else $error("stalled stage one request changed");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !col_end |=> col_q == $past(col_q) + 10'd1 && $stable(row_q))
		else $error("column counter did not step");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(col_q) && $stable(row_q))
		else $error("counters moved without a request");

endmodule

[rtl/core/csb_addr.sv]
// csb_addr: linear video memory address (x + width * y) and result register, second stage
// depends on csb_pkg
module csb_addr #(
	parameter int ADDR_BITS = csb_pkg::ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  csb_pkg::s1_t         data_s1,
	output logic                 s1_ready,
	input  logic [9:0]           screen_width,
	output logic                 write_valid,
	input  logic                 write_ready,
	output logic [ADDR_BITS-1:0] vram_address,
	output logic [7:0]           write_color
);

	localparam int SUMW = (ADDR_BITS > 20) ? ADDR_BITS : 20;

	logic                 valid_s2;
	logic [ADDR_BITS-1:0] addr_s2;
	logic [7:0]           color_s2;
	logic [18:0]          prod;
	logic [SUMW-1:0]      sum;

	assign s1_ready = !valid_s2 || write_ready;

	assign prod = {9'b0, screen_width} * {10'b0, data_s1.y};
	assign sum  = SUMW'(prod) + SUMW'(data_s1.x);

	// clipped pixels drop out here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_ready) begin
			valid_s2 <= valid_s1 && data_s1.visible;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_ready) begin
			addr_s2  <= sum[ADDR_BITS-1:0];
			color_s2 <= data_s1.color;
		end
	end

	assign write_valid  = valid_s2;
	assign vram_address = addr_s2;
	assign write_color  = color_s2;

endmodule

[rtl/core/clipped_sprite_blitter.sv]
// Clipped sprite blitter: takes one sprite pixel per cycle in raster order and issues a video
// memory write for every pixel that lands on screen; clipped pixels produce no write. Sustained
// rate is one pixel per clock while write_ready is high. Stages: clip-test register, then the
// address multiply-add and result register. Configuration writes take effect at once and
// belong between sprites while the pipeline is empty; sprite counters are not cleared by them.
// depends on csb_pkg, csb_cfg, csb_coord, csb_addr
module clipped_sprite_blitter #(
	parameter int COORD_BITS = csb_pkg::COORD_BITS_DEF,
	parameter int ADDR_BITS  = csb_pkg::ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [csb_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         pixel_valid,
	output logic                         pixel_ready,
	input  logic [7:0]                   pixel_color,
	output logic                         write_valid,
	input  logic                         write_ready,
	output logic [ADDR_BITS-1:0]         vram_address,
	output logic [7:0]                   write_color
);

	csb_pkg::cfg_t                cfg;
	logic signed [COORD_BITS-1:0] sprite_x;
	logic signed [COORD_BITS-1:0] sprite_y;
	logic                         valid_s1;
	csb_pkg::s1_t                 data_s1;
	logic                         s1_ready;

	csb_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.sprite_x  (sprite_x),
		.sprite_y  (sprite_y)
	);

	csb_coord #(.COORD_BITS(COORD_BITS)) u_coord (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_color (pixel_color),
		.cfg         (cfg),
		.sprite_x    (sprite_x),
		.sprite_y    (sprite_y),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1),
		.s1_ready    (s1_ready)
	);

	csb_addr #(.ADDR_BITS(ADDR_BITS)) u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.data_s1      (data_s1),
		.s1_ready     (s1_ready),
		.screen_width (cfg.screen_width),
		.write_valid  (write_valid),
		.write_ready  (write_ready),
		.vram_address (vram_address),
		.write_color  (write_color)
	);

endmodule
